// ===== src/vmida_pkg.sv =====
// ----------------------------------------------------------------------------
// vmida_pkg
// Shared types, codes and constants of the identifier lifecycle allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package vmida_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int TRY_W = 9;

  localparam logic [31:0] WIDE_BASE  = 32'd256;
  localparam logic [31:0] ID_MAX     = 32'hFFFF_FFFF;
  localparam logic [7:0]  NARROW_TOP = 8'd255;
  localparam logic [63:0] INC_MAX    = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef enum logic [2:0] {
    OP_ALLOC      = 3'd0,
    OP_ACTIVATE   = 3'd1,
    OP_RETIRE     = 3'd2,
    OP_QUARANTINE = 3'd3,
    OP_RELEASE    = 3'd4,
    OP_RESTORE    = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_INVALID     = 3'd1,
    ST_NONE_FREE   = 3'd2,
    ST_EXHAUSTED   = 3'd3,
    ST_WRONG_STATE = 3'd4,
    ST_NOT_READY   = 3'd5,
    ST_CONFLICT    = 3'd6,
    ST_FULL        = 3'd7
  } status_t;

  typedef enum logic [2:0] {
    LIFE_FREE        = 3'd0,
    LIFE_ALLOCATED   = 3'd1,
    LIFE_ACTIVE      = 3'd2,
    LIFE_RETIRING    = 3'd3,
    LIFE_QUARANTINED = 3'd4
  } life_t;

  typedef enum logic [1:0] {
    MODE_FREE,
    MODE_KEY,
    MODE_MINT
  } mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_MINT,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [31:0] id;
    logic [63:0] next_inc;
    logic [63:0] cur_inc;
    logic [2:0]  life;
    logic        wide;
    logic [63:0] epoch;
  } rec_t;

  typedef struct packed {
    logic accept;
    logic decode;
    logic read;
    logic step;
    logic hit_eval;
    logic miss_eval;
    logic mint_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic pre_done;
    logic scan_end;
    logic match;
    logic hit_mint;
    logic miss_mint;
    logic mint_fail;
    logic mint_skip;
    logic out_busy;
  } stat_t;

endpackage

`default_nettype wire

// ===== src/vmida_ctrl.sv =====
// ----------------------------------------------------------------------------
// vmida_ctrl
// Controller: sequences decode, table scans, id minting and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module vmida_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire vmida_pkg::stat_t stat,
  output vmida_pkg::cmd_t       cmd
);

  vmida_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vmida_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      vmida_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = vmida_pkg::S_DECODE;
        end
      end
      vmida_pkg::S_DECODE: begin
        cmd.decode = 1'b1;
        state_nxt  = stat.pre_done ? vmida_pkg::S_FINISH : vmida_pkg::S_SCAN_RD;
      end
      vmida_pkg::S_SCAN_RD: begin
        if (stat.scan_end) begin
          cmd.miss_eval = 1'b1;
          state_nxt     = stat.miss_mint ? vmida_pkg::S_MINT : vmida_pkg::S_FINISH;
        end else begin
          cmd.read  = 1'b1;
          state_nxt = vmida_pkg::S_SCAN_CHK;
        end
      end
      vmida_pkg::S_SCAN_CHK: begin
        if (stat.match) begin
          cmd.hit_eval = 1'b1;
          state_nxt    = stat.hit_mint ? vmida_pkg::S_MINT : vmida_pkg::S_FINISH;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = vmida_pkg::S_SCAN_RD;
        end
      end
      vmida_pkg::S_MINT: begin
        cmd.mint_step = 1'b1;
        if (stat.mint_fail) begin
          state_nxt = vmida_pkg::S_FINISH;
        end else if (stat.mint_skip) begin
          state_nxt = vmida_pkg::S_MINT;
        end else begin
          state_nxt = vmida_pkg::S_SCAN_RD;
        end
      end
      vmida_pkg::S_FINISH: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = vmida_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = vmida_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/vmida_dp.sv =====
// ----------------------------------------------------------------------------
// vmida_dp
// Datapath: request registers, record memory, id counters and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module vmida_dp #(
  parameter int TABLE_DEPTH = vmida_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire vmida_pkg::cmd_t  cmd,
  output vmida_pkg::stat_t      stat,
  input  wire logic [2:0]       in_kind,
  input  wire logic             in_id_kind,
  input  wire logic [31:0]      in_vm_id,
  input  wire logic [63:0]      in_incarnation,
  input  wire logic [2:0]       in_restore_state,
  input  wire logic             in_retire_ready,
  input  wire logic [63:0]      in_digest_word0,
  input  wire logic [63:0]      in_digest_word1,
  input  wire logic [63:0]      in_digest_word2,
  input  wire logic [63:0]      in_digest_word3,
  input  wire logic             cfg_valid,
  input  wire logic [63:0]      cfg_legacy_epoch,
  input  wire logic             out_ready,
  output logic                  out_valid,
  output logic [2:0]            out_status,
  output logic [31:0]           out_granted_id,
  output logic [63:0]           out_granted_incarnation
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int TW = vmida_pkg::TRY_W;
  localparam logic [CW-1:0] DEPTH_C      = CW'(TABLE_DEPTH);
  localparam logic [TW-1:0] WIDE_TRIES   = TW'(257 + TABLE_DEPTH);
  localparam logic [TW-1:0] NARROW_TRIES = TW'(255);

  vmida_pkg::rec_t rec_mem [TABLE_DEPTH];
  vmida_pkg::rec_t rd_q;

  logic [2:0]       op_r;
  logic             wide_r;
  logic [31:0]      id_r;
  logic [63:0]      inc_r;
  logic [2:0]       rstate_r;
  logic             ready_r;
  logic             dig_zero_r;
  logic [63:0]      epoch_r;
  vmida_pkg::mode_t mode_r;
  logic [31:0]      key_r;
  logic [CW-1:0]    idx_r;
  logic [CW-1:0]    used_r;
  logic [7:0]       nnar_r;
  logic [31:0]      nwide_r;
  logic [TW-1:0]    tries_r;
  logic [2:0]       res_status_r;
  logic [31:0]      res_id_r;
  logic [63:0]      res_inc_r;
  logic             out_valid_r;
  logic [2:0]       out_status_r;
  logic [31:0]      out_id_r;
  logic [63:0]      out_inc_r;

  logic             full;
  logic [63:0]      epoch_sel;
  logic             restore_bad;
  logic             pre_done;
  logic [2:0]       pre_status;
  logic             hit_apply;
  logic             cur_eq;
  logic             inc_nz;
  logic             ev_set;
  logic [2:0]       ev_status;
  logic [31:0]      ev_gid;
  logic [63:0]      ev_ginc;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  vmida_pkg::rec_t  wr_data;
  logic             append;
  logic             tries_clr;
  logic [31:0]      cand;

  assign full      = (used_r == DEPTH_C);
  assign epoch_sel = wide_r ? 64'd0 : epoch_r;
  assign cur_eq    = (rd_q.cur_inc == inc_r);
  assign inc_nz    = (inc_r != 64'd0);
  assign hit_apply = cmd.hit_eval && (mode_r != vmida_pkg::MODE_MINT);
  assign cand      = wide_r ? nwide_r : {24'd0, nnar_r};

  assign restore_bad = (id_r == 32'd0) || !inc_nz || (inc_r == vmida_pkg::INC_MAX) ||
                       (rstate_r == vmida_pkg::LIFE_FREE) ||
                       (rstate_r > vmida_pkg::LIFE_QUARANTINED) ||
                       (!wide_r && (id_r > 32'd255)) ||
                       (wide_r && (id_r < vmida_pkg::WIDE_BASE));

  always_comb begin
    pre_done   = 1'b1;
    pre_status = vmida_pkg::ST_INVALID;
    case (op_r) inside
      vmida_pkg::OP_ALLOC: begin
        pre_done = 1'b0;
      end
      vmida_pkg::OP_ACTIVATE, vmida_pkg::OP_RETIRE, vmida_pkg::OP_RELEASE: begin
        pre_done   = (id_r == 32'd0);
        pre_status = vmida_pkg::ST_WRONG_STATE;
      end
      vmida_pkg::OP_QUARANTINE: begin
        if (!ready_r) begin
          pre_status = vmida_pkg::ST_NOT_READY;
        end else if (dig_zero_r) begin
          pre_status = vmida_pkg::ST_INVALID;
        end else begin
          pre_done   = (id_r == 32'd0);
          pre_status = vmida_pkg::ST_WRONG_STATE;
        end
      end
      vmida_pkg::OP_RESTORE: begin
        pre_done = restore_bad;
      end
      default: begin
        pre_done = 1'b1;
      end
    endcase
  end

  always_comb begin
    stat.pre_done  = pre_done;
    stat.scan_end  = (idx_r == used_r);
    stat.match     = (mode_r == vmida_pkg::MODE_FREE) ?
                     ((rd_q.life == vmida_pkg::LIFE_FREE) && (rd_q.wide == wide_r) &&
                      (wide_r || (rd_q.epoch != epoch_r))) :
                     (rd_q.id == key_r);
    stat.hit_mint  = (mode_r == vmida_pkg::MODE_MINT);
    stat.miss_mint = (mode_r == vmida_pkg::MODE_FREE) && !full;
    stat.mint_fail = wide_r ? (tries_r == WIDE_TRIES) : (tries_r == NARROW_TRIES);
    stat.mint_skip = wide_r && (nwide_r < vmida_pkg::WIDE_BASE);
    stat.out_busy  = out_valid_r && !out_ready;
  end

  always_comb begin
    ev_set    = 1'b0;
    ev_status = vmida_pkg::ST_OK;
    ev_gid    = 32'd0;
    ev_ginc   = 64'd0;
    wr_en     = 1'b0;
    wr_addr   = idx_r[AW-1:0];
    wr_data   = rd_q;
    append    = 1'b0;
    tries_clr = 1'b0;
    if (hit_apply) begin
      ev_set    = 1'b1;
      ev_status = vmida_pkg::ST_WRONG_STATE;
      case (op_r)
        vmida_pkg::OP_ALLOC: begin
          if ((rd_q.id == 32'd0) || (rd_q.next_inc == 64'd0) ||
              (rd_q.next_inc == vmida_pkg::INC_MAX)) begin
            ev_status = vmida_pkg::ST_EXHAUSTED;
          end else begin
            ev_status        = vmida_pkg::ST_OK;
            wr_en            = 1'b1;
            wr_data.next_inc = rd_q.next_inc + 64'd1;
            wr_data.cur_inc  = rd_q.next_inc;
            wr_data.life     = vmida_pkg::LIFE_ALLOCATED;
            wr_data.wide     = wide_r;
            wr_data.epoch    = epoch_sel;
            ev_gid           = rd_q.id;
            ev_ginc          = rd_q.next_inc;
          end
        end
        vmida_pkg::OP_ACTIVATE: begin
          if ((rd_q.life == vmida_pkg::LIFE_ALLOCATED) && cur_eq && inc_nz) begin
            ev_status    = vmida_pkg::ST_OK;
            wr_en        = 1'b1;
            wr_data.life = vmida_pkg::LIFE_ACTIVE;
          end
        end
        vmida_pkg::OP_RETIRE: begin
          if (cur_eq && ((rd_q.life == vmida_pkg::LIFE_ALLOCATED) ||
                         (rd_q.life == vmida_pkg::LIFE_ACTIVE))) begin
            ev_status    = vmida_pkg::ST_OK;
            wr_en        = 1'b1;
            wr_data.life = vmida_pkg::LIFE_RETIRING;
          end
        end
        vmida_pkg::OP_QUARANTINE: begin
          if ((rd_q.life == vmida_pkg::LIFE_RETIRING) && cur_eq && inc_nz) begin
            ev_status    = vmida_pkg::ST_OK;
            wr_en        = 1'b1;
            wr_data.life = vmida_pkg::LIFE_QUARANTINED;
          end
        end
        vmida_pkg::OP_RELEASE: begin
          if ((rd_q.life == vmida_pkg::LIFE_QUARANTINED) && cur_eq && inc_nz) begin
            ev_status       = vmida_pkg::ST_OK;
            wr_en           = 1'b1;
            wr_data.life    = vmida_pkg::LIFE_FREE;
            wr_data.cur_inc = 64'd0;
          end
        end
        vmida_pkg::OP_RESTORE: begin
          if ((rd_q.wide == wide_r) && cur_eq && (rd_q.life == rstate_r)) begin
            ev_status = vmida_pkg::ST_OK;
          end else begin
            ev_status = vmida_pkg::ST_CONFLICT;
          end
        end
        default: begin
          ev_status = vmida_pkg::ST_INVALID;
        end
      endcase
    end else if (cmd.miss_eval) begin
      wr_addr = used_r[AW-1:0];
      case (op_r)
        vmida_pkg::OP_ALLOC: begin
          if (mode_r == vmida_pkg::MODE_MINT) begin
            ev_set           = 1'b1;
            ev_status        = vmida_pkg::ST_OK;
            wr_en            = 1'b1;
            append           = 1'b1;
            wr_data.id       = key_r;
            wr_data.next_inc = 64'd2;
            wr_data.cur_inc  = 64'd1;
            wr_data.life     = vmida_pkg::LIFE_ALLOCATED;
            wr_data.wide     = wide_r;
            wr_data.epoch    = epoch_sel;
            ev_gid           = key_r;
            ev_ginc          = 64'd1;
          end else if (full) begin
            ev_set    = 1'b1;
            ev_status = vmida_pkg::ST_NONE_FREE;
          end else begin
            tries_clr = 1'b1;
          end
        end
        vmida_pkg::OP_RESTORE: begin
          ev_set = 1'b1;
          if (full) begin
            ev_status = vmida_pkg::ST_FULL;
          end else begin
            ev_status        = vmida_pkg::ST_OK;
            wr_en            = 1'b1;
            append           = 1'b1;
            wr_data.id       = id_r;
            wr_data.next_inc = inc_r + 64'd1;
            wr_data.cur_inc  = inc_r;
            wr_data.life     = rstate_r;
            wr_data.wide     = wide_r;
            wr_data.epoch    = epoch_sel;
          end
        end
        default: begin
          ev_set    = 1'b1;
          ev_status = vmida_pkg::ST_WRONG_STATE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rec_mem[wr_addr] <= wr_data;
    end
    if (cmd.read) begin
      rd_q <= rec_mem[idx_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      epoch_r     <= 64'd0;
      used_r      <= '0;
      nnar_r      <= 8'd1;
      nwide_r     <= vmida_pkg::WIDE_BASE;
      idx_r       <= '0;
      tries_r     <= '0;
      mode_r      <= vmida_pkg::MODE_KEY;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        epoch_r <= cfg_legacy_epoch;
      end
      if (cmd.accept) begin
        op_r       <= in_kind;
        wide_r     <= in_id_kind;
        id_r       <= in_vm_id;
        inc_r      <= in_incarnation;
        rstate_r   <= in_restore_state;
        ready_r    <= in_retire_ready;
        dig_zero_r <= ((in_digest_word0 | in_digest_word1 |
                        in_digest_word2 | in_digest_word3) == 64'd0);
      end
      if (cmd.decode) begin
        res_status_r <= pre_status;
        res_id_r     <= 32'd0;
        res_inc_r    <= 64'd0;
        idx_r        <= '0;
        key_r        <= id_r;
        mode_r       <= (op_r == vmida_pkg::OP_ALLOC) ? vmida_pkg::MODE_FREE :
                                                         vmida_pkg::MODE_KEY;
      end
      if (cmd.step) begin
        idx_r <= idx_r + 1'b1;
      end
      if (ev_set) begin
        res_status_r <= ev_status;
        res_id_r     <= ev_gid;
        res_inc_r    <= ev_ginc;
      end
      if (append) begin
        used_r <= used_r + 1'b1;
        if (op_r == vmida_pkg::OP_RESTORE) begin
          if (!wide_r) begin
            if (id_r[7:0] >= nnar_r) begin
              nnar_r <= (id_r[7:0] == vmida_pkg::NARROW_TOP) ? 8'd1 : id_r[7:0] + 8'd1;
            end
          end else if (id_r >= nwide_r) begin
            nwide_r <= (id_r == vmida_pkg::ID_MAX) ? vmida_pkg::WIDE_BASE : id_r + 32'd1;
          end
        end
      end
      if (tries_clr) begin
        tries_r <= '0;
      end
      if (cmd.mint_step) begin
        if (stat.mint_fail) begin
          res_status_r <= vmida_pkg::ST_NONE_FREE;
        end else begin
          tries_r <= tries_r + 1'b1;
          key_r   <= cand;
          idx_r   <= '0;
          mode_r  <= vmida_pkg::MODE_MINT;
          if (wide_r) begin
            nwide_r <= (nwide_r == vmida_pkg::ID_MAX) ? vmida_pkg::WIDE_BASE :
                                                         nwide_r + 32'd1;
          end else begin
            nnar_r <= (nnar_r == vmida_pkg::NARROW_TOP) ? 8'd1 : nnar_r + 8'd1;
          end
        end
      end
      if (cmd.out_load) begin
        out_valid_r  <= 1'b1;
        out_status_r <= res_status_r;
        out_id_r     <= res_id_r;
        out_inc_r    <= res_inc_r;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid               = out_valid_r;
  assign out_status              = out_status_r;
  assign out_granted_id          = out_id_r;
  assign out_granted_incarnation = out_inc_r;

endmodule

`default_nettype wire

// ===== src/vm_id_lifecycle_allocator_top.sv =====
// ----------------------------------------------------------------------------
// vm_id_lifecycle_allocator_top
// Identifier lifecycle allocator: table of identifier records with allocate,
// lifecycle transitions and restore, one request at a time.
// ----------------------------------------------------------------------------
// A table scan reads the stored records one after another, and a lookup
// ends at the matching record or after the last one.
// Allocate with minting repeats the scan for every candidate id it tries.
// Throughput: one request in flight; the next is taken once the result is
// registered. Reset clears the table count and id counters, no clearing pass.
`default_nettype none

module vm_id_lifecycle_allocator_top #(
  parameter int TABLE_DEPTH = vmida_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_kind,
  input  wire logic        in_id_kind,
  input  wire logic [31:0] in_vm_id,
  input  wire logic [63:0] in_incarnation,
  input  wire logic [2:0]  in_restore_state,
  input  wire logic        in_retire_ready,
  input  wire logic [63:0] in_digest_word0,
  input  wire logic [63:0] in_digest_word1,
  input  wire logic [63:0] in_digest_word2,
  input  wire logic [63:0] in_digest_word3,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [63:0] cfg_legacy_epoch,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_status,
  output logic [31:0]      out_granted_id,
  output logic [63:0]      out_granted_incarnation
);

  vmida_pkg::cmd_t  cmd;
  vmida_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  vmida_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  vmida_dp #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_dp (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cmd                     (cmd),
    .stat                    (stat),
    .in_kind                 (in_kind),
    .in_id_kind              (in_id_kind),
    .in_vm_id                (in_vm_id),
    .in_incarnation          (in_incarnation),
    .in_restore_state        (in_restore_state),
    .in_retire_ready         (in_retire_ready),
    .in_digest_word0         (in_digest_word0),
    .in_digest_word1         (in_digest_word1),
    .in_digest_word2         (in_digest_word2),
    .in_digest_word3         (in_digest_word3),
    .cfg_valid               (cfg_valid),
    .cfg_legacy_epoch        (cfg_legacy_epoch),
    .out_ready               (out_ready),
    .out_valid               (out_valid),
    .out_status              (out_status),
    .out_granted_id          (out_granted_id),
    .out_granted_incarnation (out_granted_incarnation)
  );

  a_grant_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != vmida_pkg::ST_OK) |->
      (out_granted_id == 32'd0) && (out_granted_incarnation == 64'd0))
    else $error("grant fields set on a failed request");

  a_grant_has_inc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_granted_id != 32'd0) |-> (out_granted_incarnation != 64'd0))
    else $error("granted id without incarnation");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while one is in flight");

endmodule

`default_nettype wire

// ===== tb/tb_vm_id_lifecycle_allocator_top.sv =====
// ----------------------------------------------------------------------------
// tb_vm_id_lifecycle_allocator_top
// Self-checking testbench of the identifier lifecycle allocator. A queue of
// requests feeds a clocked driver, a clocked monitor checks every response
// against a predictor that keeps its own copy of the record table, and the
// legacy epoch is rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_vm_id_lifecycle_allocator_top;

  localparam int DEPTH = vmida_pkg::TABLE_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 1500000;

  typedef struct {
    logic [2:0]  kind;
    logic        id_kind;
    logic [31:0] vm_id;
    logic [63:0] incarnation;
    logic [2:0]  restore_state;
    logic        retire_ready;
    logic [63:0] digest [4];
  } request_t;

  typedef struct {
    vmida_pkg::status_t status;
    logic [31:0]        id;
    logic [63:0]        inc;
  } grant_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_kind = '0;
  logic        in_id_kind = 1'b0;
  logic [31:0] in_vm_id = '0;
  logic [63:0] in_incarnation = '0;
  logic [2:0]  in_restore_state = '0;
  logic        in_retire_ready = 1'b0;
  logic [63:0] in_digest_word0 = '0;
  logic [63:0] in_digest_word1 = '0;
  logic [63:0] in_digest_word2 = '0;
  logic [63:0] in_digest_word3 = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [63:0] cfg_legacy_epoch = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_status;
  logic [31:0] out_granted_id;
  logic [63:0] out_granted_incarnation;

  vm_id_lifecycle_allocator_top #(.TABLE_DEPTH(DEPTH)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_kind(in_kind),
    .in_id_kind(in_id_kind), .in_vm_id(in_vm_id), .in_incarnation(in_incarnation),
    .in_restore_state(in_restore_state), .in_retire_ready(in_retire_ready),
    .in_digest_word0(in_digest_word0), .in_digest_word1(in_digest_word1),
    .in_digest_word2(in_digest_word2), .in_digest_word3(in_digest_word3),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_legacy_epoch(cfg_legacy_epoch),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_granted_id(out_granted_id), .out_granted_incarnation(out_granted_incarnation)
  );

  always #10 clk = ~clk;

  // Predicted table contents.
  logic [31:0]      tab_id [DEPTH];
  logic [63:0]      tab_next [DEPTH];
  logic [63:0]      tab_cur [DEPTH];
  vmida_pkg::life_t tab_life [DEPTH];
  logic             tab_wide [DEPTH];
  logic [63:0]      tab_epoch [DEPTH];
  int               tab_used = 0;
  logic [31:0]      wide_ctr = vmida_pkg::WIDE_BASE;
  logic [7:0]       narrow_ctr = 8'd1;
  logic [63:0]      epoch_now = '0;

  request_t pending_q [$];
  grant_t   grants_q [$];
  request_t in_flight;
  bit       quiet = 1'b0;
  int       errors = 0;
  int       cycles = 0;

  function automatic int find_id(logic [31:0] id);
    if (id == 0) return -1;
    for (int i = 0; i < tab_used; i++) if (tab_id[i] == id) return i;
    return -1;
  endfunction

  function automatic void put_rec(int i, logic [31:0] id, logic [63:0] nxt, logic [63:0] cur,
                                  vmida_pkg::life_t life, logic wide, logic [63:0] ep);
    tab_id[i] = id; tab_next[i] = nxt; tab_cur[i] = cur;
    tab_life[i] = life; tab_wide[i] = wide; tab_epoch[i] = ep;
  endfunction

  function automatic bit mint_fresh(logic wide, output logic [31:0] id);
    logic [31:0] cand;
    id = '0;
    if (!wide) begin
      for (int t = 0; t < 255; t++) begin
        cand = {24'd0, narrow_ctr};
        narrow_ctr = (narrow_ctr == vmida_pkg::NARROW_TOP) ? 8'd1 : narrow_ctr + 8'd1;
        if (find_id(cand) < 0) begin
          id = cand;
          return 1'b1;
        end
      end
      return 1'b0;
    end
    for (int t = 0; t < 257 + DEPTH; t++) begin
      cand = wide_ctr;
      wide_ctr = (cand == vmida_pkg::ID_MAX) ? vmida_pkg::WIDE_BASE : cand + 32'd1;
      if (cand >= vmida_pkg::WIDE_BASE && find_id(cand) < 0) begin
        id = cand;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic grant_t alloc_grant(logic wide);
    grant_t g;
    int r;
    logic [31:0] id;
    g = '{vmida_pkg::ST_OK, 32'd0, 64'd0};
    r = -1;
    for (int i = 0; i < tab_used; i++) begin
      if (tab_life[i] == vmida_pkg::LIFE_FREE && tab_wide[i] == wide &&
          (wide || tab_epoch[i] != epoch_now)) begin
        r = i;
        break;
      end
    end
    if (r < 0) begin
      if (tab_used >= DEPTH || !mint_fresh(wide, id)) begin
        g.status = vmida_pkg::ST_NONE_FREE;
        return g;
      end
      r = tab_used;
      tab_used++;
      put_rec(r, id, 64'd1, 64'd0, vmida_pkg::LIFE_FREE, wide, 64'd0);
    end
    if (tab_id[r] == 0 || tab_next[r] == 0 || tab_next[r] == vmida_pkg::INC_MAX) begin
      g.status = vmida_pkg::ST_EXHAUSTED;
      return g;
    end
    put_rec(r, tab_id[r], tab_next[r] + 64'd1, tab_next[r], vmida_pkg::LIFE_ALLOCATED, wide,
            wide ? 64'd0 : epoch_now);
    g.id = tab_id[r];
    g.inc = tab_cur[r];
    return g;
  endfunction

  function automatic vmida_pkg::status_t restore_status(request_t q);
    int r;
    if (q.vm_id == 0 || q.incarnation == 0 || q.incarnation == vmida_pkg::INC_MAX ||
        q.restore_state == vmida_pkg::LIFE_FREE ||
        q.restore_state > vmida_pkg::LIFE_QUARANTINED ||
        (!q.id_kind && q.vm_id > 32'd255) || (q.id_kind && q.vm_id < vmida_pkg::WIDE_BASE))
      return vmida_pkg::ST_INVALID;
    r = find_id(q.vm_id);
    if (r >= 0) begin
      if (tab_wide[r] != q.id_kind || tab_cur[r] != q.incarnation ||
          tab_life[r] != vmida_pkg::life_t'(q.restore_state))
        return vmida_pkg::ST_CONFLICT;
      return vmida_pkg::ST_OK;
    end
    if (tab_used >= DEPTH) return vmida_pkg::ST_FULL;
    put_rec(tab_used, q.vm_id, q.incarnation + 64'd1, q.incarnation,
            vmida_pkg::life_t'(q.restore_state), q.id_kind, q.id_kind ? 64'd0 : epoch_now);
    tab_used++;
    if (!q.id_kind) begin
      if (q.vm_id[7:0] >= narrow_ctr)
        narrow_ctr = (q.vm_id[7:0] == vmida_pkg::NARROW_TOP) ? 8'd1 : q.vm_id[7:0] + 8'd1;
    end else if (q.vm_id >= wide_ctr) begin
      wide_ctr = (q.vm_id == vmida_pkg::ID_MAX) ? vmida_pkg::WIDE_BASE : q.vm_id + 32'd1;
    end
    return vmida_pkg::ST_OK;
  endfunction

  function automatic int match_rec(request_t q, vmida_pkg::life_t want);
    int r;
    r = find_id(q.vm_id);
    if (r < 0 || tab_life[r] != want || tab_cur[r] != q.incarnation || q.incarnation == 0)
      return -1;
    return r;
  endfunction

  function automatic grant_t predict_grant(request_t q);
    grant_t g;
    int r;
    g = '{vmida_pkg::ST_WRONG_STATE, 32'd0, 64'd0};
    case (q.kind)
      vmida_pkg::OP_ALLOC: g = alloc_grant(q.id_kind);
      vmida_pkg::OP_ACTIVATE: begin
        r = match_rec(q, vmida_pkg::LIFE_ALLOCATED);
        if (r >= 0) begin
          tab_life[r] = vmida_pkg::LIFE_ACTIVE;
          g.status = vmida_pkg::ST_OK;
        end
      end
      vmida_pkg::OP_RETIRE: begin
        r = find_id(q.vm_id);
        if (r >= 0 && tab_cur[r] == q.incarnation &&
            (tab_life[r] == vmida_pkg::LIFE_ALLOCATED ||
             tab_life[r] == vmida_pkg::LIFE_ACTIVE)) begin
          tab_life[r] = vmida_pkg::LIFE_RETIRING;
          g.status = vmida_pkg::ST_OK;
        end
      end
      vmida_pkg::OP_QUARANTINE: begin
        if (!q.retire_ready) g.status = vmida_pkg::ST_NOT_READY;
        else if ((q.digest[0] | q.digest[1] | q.digest[2] | q.digest[3]) == 0)
          g.status = vmida_pkg::ST_INVALID;
        else begin
          r = match_rec(q, vmida_pkg::LIFE_RETIRING);
          if (r >= 0) begin
            tab_life[r] = vmida_pkg::LIFE_QUARANTINED;
            g.status = vmida_pkg::ST_OK;
          end
        end
      end
      vmida_pkg::OP_RELEASE: begin
        r = match_rec(q, vmida_pkg::LIFE_QUARANTINED);
        if (r >= 0) begin
          tab_life[r] = vmida_pkg::LIFE_FREE;
          tab_cur[r] = 64'd0;
          g.status = vmida_pkg::ST_OK;
        end
      end
      vmida_pkg::OP_RESTORE: g.status = restore_status(q);
      default: g.status = vmida_pkg::ST_INVALID;
    endcase
    return g;
  endfunction

  always @(posedge clk) begin
    bit holding;
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
    if (rst_n) begin
      holding = in_valid;
      if (in_valid && in_ready) begin
        grants_q.push_back(predict_grant(in_flight));
        holding = 1'b0;
      end
      if (!holding) begin
        if (pending_q.size() > 0 && (quiet || $urandom_range(99) >= 33)) begin
          in_flight = pending_q.pop_front();
          in_valid <= 1'b1;
          in_kind <= in_flight.kind;
          in_id_kind <= in_flight.id_kind;
          in_vm_id <= in_flight.vm_id;
          in_incarnation <= in_flight.incarnation;
          in_restore_state <= in_flight.restore_state;
          in_retire_ready <= in_flight.retire_ready;
          in_digest_word0 <= in_flight.digest[0];
          in_digest_word1 <= in_flight.digest[1];
          in_digest_word2 <= in_flight.digest[2];
          in_digest_word3 <= in_flight.digest[3];
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= quiet || $urandom_range(99) >= 33;
    end
  end

  always @(posedge clk) begin
    grant_t g;
    if (rst_n && out_valid && out_ready) begin
      if (grants_q.size() == 0) begin
        $error("response with nothing outstanding: status %0d", out_status);
        errors++;
      end else begin
        g = grants_q.pop_front();
        if (out_status !== g.status) begin
          $error("status: expected %0d, actual %0d", g.status, out_status);
          errors++;
        end
        if (out_granted_id !== g.id) begin
          $error("granted_id: expected %0h, actual %0h", g.id, out_granted_id);
          errors++;
        end
        if (out_granted_incarnation !== g.inc) begin
          $error("granted_incarnation: expected %0h, actual %0h", g.inc,
                 out_granted_incarnation);
          errors++;
        end
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic request_t make_req(logic [2:0] kind, logic wide, logic [31:0] id,
                                        logic [63:0] inc, logic [2:0] st);
    request_t q;
    q.kind = kind; q.id_kind = wide; q.vm_id = id; q.incarnation = inc;
    q.restore_state = st; q.retire_ready = 1'b1;
    for (int i = 0; i < 4; i++) q.digest[i] = rand64();
    return q;
  endfunction

  task automatic send(request_t q);
    pending_q.push_back(q);
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (pending_q.size() > 0 || in_valid || grants_q.size() > 0);
  endtask

  task automatic write_epoch(logic [63:0] v);
    wait_idle();
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_legacy_epoch <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    epoch_now = v;
    cfg_valid <= 1'b0;
    cfg_legacy_epoch <= rand64();
  endtask

  // Requests are mostly the legal next step of a stored record, built from the
  // predicted table as it stands when the batch is made.
  task automatic random_batch(int n);
    request_t q;
    int r, pick;
    logic wide;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      wide = 1'($urandom_range(1));
      q = make_req(vmida_pkg::OP_ALLOC, wide, $urandom, rand64(), 3'($urandom_range(7)));
      q.retire_ready = 1'($urandom_range(1));
      if (pick < 10) begin
        q.kind = 3'($urandom_range(7));
      end else if (pick < 25 || tab_used == 0) begin
        q.kind = vmida_pkg::OP_ALLOC;
      end else if (pick < 35) begin
        q.kind = vmida_pkg::OP_RESTORE;
        q.restore_state = 3'($urandom_range(1, 4));
        q.incarnation = $urandom_range(3) == 0 ? rand64() : 64'($urandom_range(1, 50));
        if ($urandom_range(2) == 0) begin
          r = $urandom_range(tab_used - 1);
          q.vm_id = tab_id[r];
          q.id_kind = tab_wide[r];
          if ($urandom_range(1)) begin
            q.incarnation = tab_cur[r];
            q.restore_state = tab_life[r];
          end
        end else if (!wide) begin
          q.vm_id = 32'($urandom_range(1, 255));
        end else begin
          q.vm_id = $urandom_range(3) == 0 ? 32'($urandom_range(256, 400)) :
                    ($urandom | 32'h100);
        end
      end else begin
        r = $urandom_range(tab_used - 1);
        q.vm_id = tab_id[r];
        q.id_kind = tab_wide[r];
        q.incarnation = tab_cur[r];
        q.retire_ready = $urandom_range(19) != 0;
        case (tab_life[r])
          vmida_pkg::LIFE_FREE:      q.kind = vmida_pkg::OP_ALLOC;
          vmida_pkg::LIFE_ALLOCATED: q.kind = $urandom_range(3) == 0 ? vmida_pkg::OP_RETIRE :
                                                                       vmida_pkg::OP_ACTIVATE;
          vmida_pkg::LIFE_ACTIVE:    q.kind = vmida_pkg::OP_RETIRE;
          vmida_pkg::LIFE_RETIRING:  q.kind = vmida_pkg::OP_QUARANTINE;
          default:                   q.kind = vmida_pkg::OP_RELEASE;
        endcase
        if ($urandom_range(9) == 0) q.incarnation = q.incarnation ^ 64'd1;
      end
      send(q);
    end
  endtask

  task automatic random_phase(int n);
    for (int done = 0; done < n; done += 8) begin
      random_batch(8);
      wait_idle();
    end
  endtask

  initial begin
    request_t q;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    write_epoch(64'd0);

    send(make_req(3'd6, 1'b0, 32'd5, 64'd1, 3'd1));
    send(make_req(3'd7, 1'b1, vmida_pkg::ID_MAX, vmida_pkg::INC_MAX, 3'd7));
    send(make_req(vmida_pkg::OP_ACTIVATE, 1'b0, 32'd0, 64'd1, 3'd0));
    send(make_req(vmida_pkg::OP_RESTORE, 1'b0, 32'd0, 64'd1, 3'd1));
    send(make_req(vmida_pkg::OP_RESTORE, 1'b0, 32'd9, 64'd0, 3'd1));
    send(make_req(vmida_pkg::OP_RESTORE, 1'b0, 32'd9, vmida_pkg::INC_MAX, 3'd1));
    send(make_req(vmida_pkg::OP_RESTORE, 1'b0, 32'd9, 64'd1, 3'd0));
    send(make_req(vmida_pkg::OP_RESTORE, 1'b0, 32'd9, 64'd1, 3'd5));
    send(make_req(vmida_pkg::OP_RESTORE, 1'b0, 32'd300, 64'd1, 3'd1));
    send(make_req(vmida_pkg::OP_RESTORE, 1'b1, 32'd255, 64'd1, 3'd1));
    send(make_req(vmida_pkg::OP_RESTORE, 1'b0, 32'd255, 64'd1, 3'd1));
    send(make_req(vmida_pkg::OP_RESTORE, 1'b1, vmida_pkg::ID_MAX, 64'd5, 3'd2));
    send(make_req(vmida_pkg::OP_RESTORE, 1'b1, vmida_pkg::ID_MAX, 64'd5, 3'd2));
    send(make_req(vmida_pkg::OP_RESTORE, 1'b1, vmida_pkg::ID_MAX, 64'd6, 3'd2));
    send(make_req(vmida_pkg::OP_ALLOC, 1'b1, 32'd0, 64'd0, 3'd0));
    send(make_req(vmida_pkg::OP_ALLOC, 1'b0, 32'd0, 64'd0, 3'd0));
    send(make_req(vmida_pkg::OP_ACTIVATE, 1'b0, 32'd255, 64'd0, 3'd0));
    send(make_req(vmida_pkg::OP_ACTIVATE, 1'b0, 32'd255, 64'd1, 3'd0));
    send(make_req(vmida_pkg::OP_RETIRE, 1'b0, 32'd255, 64'd1, 3'd0));
    q = make_req(vmida_pkg::OP_QUARANTINE, 1'b0, 32'd255, 64'd1, 3'd0);
    q.retire_ready = 1'b0;
    send(q);
    q.retire_ready = 1'b1;
    q.digest = '{64'd0, 64'd0, 64'd0, 64'd0};
    send(q);
    q.digest = '{vmida_pkg::INC_MAX, vmida_pkg::INC_MAX, vmida_pkg::INC_MAX,
                 vmida_pkg::INC_MAX};
    send(q);
    send(make_req(vmida_pkg::OP_RELEASE, 1'b0, 32'd255, 64'd1, 3'd0));
    send(make_req(vmida_pkg::OP_RESTORE, 1'b0, 32'd200, vmida_pkg::INC_MAX - 64'd1, 3'd4));
    send(make_req(vmida_pkg::OP_RELEASE, 1'b0, 32'd200, vmida_pkg::INC_MAX - 64'd1, 3'd0));
    wait_idle();

    random_phase(85);
    write_epoch(vmida_pkg::INC_MAX);
    quiet = 1'b1;
    random_phase(85);
    quiet = 1'b0;
    write_epoch(rand64());
    random_phase(85);
    write_epoch(64'd1);
    random_phase(85);
    write_epoch(64'd0);
    random_phase(85);

    wait_idle();
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
